@@ hw/rtl/zzs_pkg.sv @@
// Shared types, constants and helpers for the zigzag scan reorder block.
// No dependencies; imported by zzs_walker, zigzag_scan_reorder, zzs_scan_checker and testbench.
package zzs_pkg;

	localparam int MAX_ROWS_DEF    = 8;
	localparam int MAX_COLUMNS_DEF = 8;

	localparam int VALUE_W = 32;
	localparam int SIZE_W  = 4;   // row_count / column_count registers
	localparam int POS_W   = 3;   // out_row / out_column
	localparam int DIAG_W  = 4;   // diagonal number, up to 14
	localparam int FILL_W  = 7;   // fill count and scan count, up to 64
	localparam int CIDX_W  = 2;   // configuration register index

	typedef enum logic [CIDX_W-1:0] {
		CFG_ROW_COUNT    = 2'd0,
		CFG_COLUMN_COUNT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} scan_state_t;

	// current scan position from the walker
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic             last;
	} scan_pos_t;

	// a size of 0 acts as 1, anything above the maximum acts as the maximum
	function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
			logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] res;
		if (v == '0) begin
			res = SIZE_W'(1);
		end else if (v > maxv) begin
			res = maxv;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/zzs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module zzs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/zzs_walker.sv @@
// Zigzag position walker: steps row/column through the diagonals one per step.
// Depends on zzs_pkg.
module zzs_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        step,
	input  logic [zzs_pkg::SIZE_W-1:0]  rows,
	input  logic [zzs_pkg::SIZE_W-1:0]  cols,
	input  logic [zzs_pkg::FILL_W-1:0]  total,
	output zzs_pkg::scan_pos_t          pos
);
	import zzs_pkg::*;

	logic [POS_W-1:0]  row_q, col_q, row_nx, col_nx;
	logic [DIAG_W-1:0] diag_q, diag_nx, dn;
	logic [FILL_W-1:0] cnt_q;
	logic [SIZE_W-1:0] rows_m1, cols_m1, rn, cn;
	logic              walk_on;

	assign rows_m1 = rows - SIZE_W'(1);
	assign cols_m1 = cols - SIZE_W'(1);
	assign dn      = diag_q + DIAG_W'(1);

	always_comb begin
		// stay on the diagonal unless the walk hits an edge
		if (!diag_q[0]) begin
			walk_on = (row_q != '0) && ((SIZE_W'(col_q) + SIZE_W'(1)) < cols);
		end else begin
			walk_on = (col_q != '0) && ((SIZE_W'(row_q) + SIZE_W'(1)) < rows);
		end

		if (dn[0]) begin
			cn = (dn < cols_m1) ? dn : cols_m1;
			rn = dn - cn;
		end else begin
			rn = (dn < rows_m1) ? dn : rows_m1;
			cn = dn - rn;
		end

		if (walk_on) begin
			diag_nx = diag_q;
			if (!diag_q[0]) begin
				row_nx = row_q - POS_W'(1);
				col_nx = col_q + POS_W'(1);
			end else begin
				row_nx = row_q + POS_W'(1);
				col_nx = col_q - POS_W'(1);
			end
		end else begin
			diag_nx = dn;
			row_nx  = rn[POS_W-1:0];
			col_nx  = cn[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			diag_q <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			row_q  <= '0;
			col_q  <= '0;
			diag_q <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			row_q  <= row_nx;
			col_q  <= col_nx;
			diag_q <= diag_nx;
			cnt_q  <= cnt_q + FILL_W'(1);
		end
	end

	assign pos.row    = row_q;
	assign pos.column = col_q;
	assign pos.last   = ((cnt_q + FILL_W'(1)) == total);

endmodule

@@ hw/rtl/zigzag_scan_reorder.sv @@
// Zigzag scan reorder: takes a matrix of up to MAX_ROWS x MAX_COLUMNS signed 32-bit
// elements in row-major order, one per cycle, into an element RAM. The transfer of
// the element that completes the matrix starts a scan that returns every element in
// zigzag diagonal order with its row and column, the final one flagged last_of_scan.
// The RAM has one registered read port; a read is issued only once the previous read has
// landed and the output register will be free, so no more than one read is in flight and
// a new read waits on the last one. No input is taken until the last read of
// the scan has been issued. Sizes of 0 act as 1, larger than the maximum act as the
// maximum. Write configuration only while the block is idle.
// Depends on zzs_pkg, zzs_ram and zzs_walker.
module zigzag_scan_reorder #(
	parameter int MAX_ROWS    = zzs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = zzs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [zzs_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [zzs_pkg::SIZE_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [zzs_pkg::VALUE_W-1:0] element_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [zzs_pkg::VALUE_W-1:0] out_value,
	output logic [zzs_pkg::POS_W-1:0]    out_row,
	output logic [zzs_pkg::POS_W-1:0]    out_column,
	output logic                         last_of_scan
);
	import zzs_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	scan_state_t       state_q;
	logic [SIZE_W-1:0] row_count_q, column_count_q, rows, cols;
	logic [FILL_W-1:0] fill_q, fill_nx, total;
	logic              in_xfer, complete, issue;
	scan_pos_t         pos;
	logic [FILL_W-1:0] rd_addr_full;
	logic [VALUE_W-1:0] rd_data;

	logic              valid_s1;
	logic [POS_W-1:0]  row_s1, col_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [POS_W-1:0]  out_row_q, out_column_q;
	logic              out_last_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= SIZE_W'(8);
			column_count_q <= SIZE_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_COUNT:    row_count_q    <= cfg_data;
				CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows  = clamp_size(row_count_q, SIZE_W'(MAX_ROWS));
	assign cols  = clamp_size(column_count_q, SIZE_W'(MAX_COLUMNS));
	assign total = FILL_W'(rows) * FILL_W'(cols);

	// fill side
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign fill_nx  = fill_q + FILL_W'(1);
	assign complete = in_xfer && (fill_nx >= total);

	// scan side: one read in flight, output register must be free when it lands
	assign issue = (state_q == ST_SCAN) && !valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (complete) begin
						state_q <= ST_SCAN;
						fill_q  <= '0;
					end else if (in_xfer) begin
						fill_q <= fill_nx;
					end
				end
				ST_SCAN: begin
					if (issue && pos.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	zzs_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (complete),
		.step   (issue),
		.rows   (rows),
		.cols   (cols),
		.total  (total),
		.pos    (pos)
	);

	assign rd_addr_full = FILL_W'(pos.row) * FILL_W'(cols) + FILL_W'(pos.column);

	zzs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (fill_q[AW-1:0]),
		.wdata (element_value),
		.re    (issue),
		.raddr (rd_addr_full[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1  <= pos.row;
			col_s1  <= pos.column;
			last_s1 <= pos.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_value_q  <= rd_data;
			out_row_q    <= row_s1;
			out_column_q <= col_s1;
			out_last_q   <= last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_row      = out_row_q;
	assign out_column   = out_column_q;
	assign last_of_scan = out_last_q;

	// read data must never land on a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !out_valid_q)
		else $error("read data landed on an occupied output register");

	a_fill_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (fill_q == '0))
		else $error("fill count not cleared during scan");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && pos.last) |=> (state_q == ST_IDLE))
		else $error("scan did not end after its last read");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("scan state not one-hot");

endmodule

@@ tb/sv/zzs_scan_checker.sv @@
// Checker for zigzag_scan_reorder: follows configuration, element and result transfers,
// predicts each zigzag scan from its own copy of the matrix and compares results in order.
// Depends on zzs_pkg.
module zzs_scan_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [zzs_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [zzs_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [zzs_pkg::VALUE_W-1:0] element_value,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [zzs_pkg::VALUE_W-1:0] out_value,
	input  logic [zzs_pkg::POS_W-1:0]          out_row,
	input  logic [zzs_pkg::POS_W-1:0]          out_column,
	input  logic                               last_of_scan,
	output int                                 mismatches,
	output int                                 scan_backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	import zzs_pkg::*;

	localparam int CELLS = MAX_ROWS_DEF * MAX_COLUMNS_DEF;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          row;
		logic [POS_W-1:0]          column;
		logic                      last;
	} scan_result_t;

	logic signed [VALUE_W-1:0] matrix_mem [CELLS];
	logic [FILL_W-1:0]         fill;
	logic [SIZE_W-1:0]         rows_reg;
	logic [SIZE_W-1:0]         cols_reg;
	scan_result_t              zigzag_q [$];

	function automatic int size_in_use(logic [SIZE_W-1:0] v, int maxv);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > maxv) begin
			return maxv;
		end
		return int'(v);
	endfunction

	// walks the diagonals; even ones run up-right (row falling), odd ones down-left
	function automatic void queue_zigzag_scan(int nrows, int ncols);
		int k;
		int r_hi;
		int r_lo;
		int r;
		int c;
		scan_result_t res;
		k = 0;
		for (int d = 0; d <= nrows + ncols - 2; d++) begin
			r_hi = (d < nrows - 1) ? d : nrows - 1;
			r_lo = (d > ncols - 1) ? d - ncols + 1 : 0;
			for (int i = 0; i <= r_hi - r_lo; i++) begin
				r = (d % 2 == 0) ? r_hi - i : r_lo + i;
				c = d - r;
				k++;
				res.value  = matrix_mem[r * ncols + c];
				res.row    = POS_W'(r);
				res.column = POS_W'(c);
				res.last   = (k == nrows * ncols);
				zigzag_q.push_back(res);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		scan_result_t got;
		scan_result_t want;
		int nrows;
		int ncols;
		if (!arst_n) begin
			fill = '0;
			rows_reg = SIZE_W'(MAX_ROWS_DEF);
			cols_reg = SIZE_W'(MAX_COLUMNS_DEF);
			zigzag_q.delete();
			mismatches <= 0;
			scan_backlog <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{out_value, out_row, out_column, last_of_scan};
				if (zigzag_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got value %0d row %0d",
						$time, got.value, got.row,
						" column %0d last %0b", got.column, got.last);
					mismatches <= mismatches + 1;
				end else begin
					want = zigzag_q.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch: expected value %0d row %0d",
							$time, want.value, want.row,
							" column %0d last %0b, got value %0d row %0d",
							want.column, want.last, got.value, got.row,
							" column %0d last %0b", got.column, got.last);
						mismatches <= mismatches + 1;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROW_COUNT: rows_reg = cfg_data;
					CFG_COLUMN_COUNT: cols_reg = cfg_data;
					default: ;
				endcase
			end

			// fill count survives a resize; the scan fires once it covers the matrix
			if (in_valid && in_ready) begin
				matrix_mem[fill[5:0]] = element_value;
				fill = fill + FILL_W'(1);
				nrows = size_in_use(rows_reg, MAX_ROWS_DEF);
				ncols = size_in_use(cols_reg, MAX_COLUMNS_DEF);
				if (int'(fill) >= nrows * ncols) begin
					queue_zigzag_scan(nrows, ncols);
					fill = '0;
				end
			end

			scan_backlog <= zigzag_q.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the zigzag_scan_reorder testbench: clock, reset, configuration and element
// stimulus with random back-pressure, and the verdict. Depends on zzs_pkg,
// zzs_scan_checker and the zigzag_scan_reorder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import zzs_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE       = 8;
	localparam int SCAN_DRAIN   = 2 * MAX_ROWS_DEF * MAX_COLUMNS_DEF + 16;
	localparam int RANDOM_ITEMS = 250;
	localparam int PHASE_LEN    = 90;
	localparam int RUN_LIMIT    = 20_000_000;

	// indexes with no register behind them
	localparam logic [CIDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CIDX_W-1:0]         cfg_index = '0;
	logic [SIZE_W-1:0]         cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [VALUE_W-1:0] element_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] out_value;
	logic [POS_W-1:0]          out_row;
	logic [POS_W-1:0]          out_column;
	logic                      last_of_scan;

	int mismatches;
	int scan_backlog;
	int send_idle = 29;
	int recv_idle = 67;
	int elements_sent = 0;

	zigzag_scan_reorder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_row      (out_row),
		.out_column   (out_column),
		.last_of_scan (last_of_scan)
	);

	zzs_scan_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_row      (out_row),
		.out_column   (out_column),
		.last_of_scan (last_of_scan),
		.mismatches   (mismatches),
		.scan_backlog (scan_backlog)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_element(input logic signed [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		elements_sent++;
		// idle pattern swaps sides, then stops
		if (elements_sent == PHASE_LEN) begin
			send_idle = 67;
			recv_idle <= 29;
		end else if (elements_sent == 2 * PHASE_LEN) begin
			send_idle = 0;
			recv_idle <= 0;
		end
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and wait for the block to go quiet
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (scan_backlog != 0);
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
		int eff_rows;
		int eff_cols;
		int n;
		int random_sent;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as 1x1: every element comes straight back
		write_reg(CFG_ROW_COUNT, '0);
		write_reg(CFG_COLUMN_COUNT, '0);
		send_element(32'sh8000_0000);
		send_element(32'sh7fff_ffff);
		send_element(32'sh0000_0000);
		send_element(32'shffff_ffff);

		settle(SETTLE);
		write_reg(CFG_SPARE_A, 4'hf);
		write_reg(CFG_ROW_COUNT, 4'd2);
		write_reg(CFG_COLUMN_COUNT, 4'd3);
		write_reg(CFG_SPARE_B, 4'h1);
		repeat (6) send_element($urandom());

		// rows above the maximum clamp to 8: single column
		settle(SETTLE);
		write_reg(CFG_ROW_COUNT, 4'hf);
		write_reg(CFG_COLUMN_COUNT, 4'd1);
		repeat (8) send_element($urandom());

		// shrink the matrix part way through a fill
		settle(SETTLE);
		write_reg(CFG_ROW_COUNT, 4'd2);
		write_reg(CFG_COLUMN_COUNT, 4'd2);
		repeat (3) send_element($urandom());
		settle(SETTLE);
		write_reg(CFG_ROW_COUNT, 4'd1);
		write_reg(CFG_COLUMN_COUNT, 4'd2);
		send_element($urandom());

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			settle(SETTLE);
			if ($urandom_range(7) == 0) begin
				rows = SIZE_W'($urandom_range(15));
				cols = SIZE_W'($urandom_range(15));
			end else begin
				rows = SIZE_W'($urandom_range(4, 1));
				cols = SIZE_W'($urandom_range(4, 1));
			end
			if ($urandom_range(9) == 0) begin
				write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
					SIZE_W'($urandom_range(15)));
			end
			write_reg(CFG_ROW_COUNT, rows);
			write_reg(CFG_COLUMN_COUNT, cols);
			eff_rows = (rows == 0) ? 1 : (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
			eff_cols = (cols == 0) ? 1 : (cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols;
			n = eff_rows * eff_cols;
			// now and then leave a matrix unfinished so the fill carries into a resize
			if ($urandom_range(4) == 0) begin
				n = $urandom_range(n);
			end
			repeat (n) begin
				send_element($urandom());
				random_sent++;
			end
		end

		settle(SCAN_DRAIN);
		if (mismatches == 0 && scan_backlog == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
